>>> rtl/sncag_pkg.sv
// Shared types, widths and codes for the strided N-d copy address generator.
// No dependencies; sncag_cell, the top level and sncag_chk import this package.
`timescale 1ns / 1ps
`default_nettype none

package sncag_pkg;

  localparam int unsigned MAX_RANK_DEF   = 4;
  localparam int unsigned ADDR_WIDTH_DEF = 48;

  localparam int unsigned FIELD_ADDR_W = 48;
  localparam int unsigned EXTENT_W     = 16;
  localparam int unsigned STRIDE_W     = 32;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned ELEM_W       = 7;
  localparam int unsigned RANK_W       = 3;
  localparam int unsigned AXIS_W       = 2;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 7;

  // 1 - extent as a signed value, its product with elem_size, and the rewind product
  localparam int unsigned SCALE_W = EXTENT_W + 2;
  localparam int unsigned K_W     = SCALE_W + ELEM_W + 1;
  localparam int unsigned RW_W    = STRIDE_W + K_W;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_NEXT  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEM_SIZE = 1'b0,
    CFG_RANK      = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REWIND,
    ST_START,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic [AXIS_W-1:0]          axis;
    logic [EXTENT_W-1:0]        extent;
    logic signed [STRIDE_W-1:0] src_stride;
    logic signed [STRIDE_W-1:0] dst_stride;
    logic [FIELD_ADDR_W-1:0]    src_addr;
    logic [OFFSET_W-1:0]        src_offset;
    logic [FIELD_ADDR_W-1:0]    dst_addr;
    logic [OFFSET_W-1:0]        dst_offset;
  } in_item_t;

  typedef struct packed {
    logic                    valid_res;
    logic [FIELD_ADDR_W-1:0] read_addr;
    logic [FIELD_ADDR_W-1:0] write_addr;
    logic                    last;
    logic                    done_res;
  } out_item_t;

  // Per-axis control from the sequencer to the row of axis slices
  typedef struct packed {
    logic step;
    logic shift;
    logic clr;
    logic load;
    logic rewind;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/sncag_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Standalone; the payload type is given at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface sncag_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/sncag_cell.sv
// One axis slice: extent, counter, byte strides, rewind steps and a term register.
// Carry enters from the inner neighbor, terms shift toward the outer neighbor. Uses sncag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sncag_cell #(
  parameter int unsigned ADDR_WIDTH = sncag_pkg::ADDR_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sncag_pkg::cell_ctrl_t             ctrl_i,
  input  logic                              sel_i,
  input  logic                              in_use_i,
  input  logic                              outer_i,
  input  logic                              carry_i,
  output logic                              carry_o,
  output logic                              ext_zero_o,
  input  logic [sncag_pkg::EXTENT_W-1:0]    ld_extent_i,
  input  logic [ADDR_WIDTH-1:0]             ld_src_stride_i,
  input  logic [ADDR_WIDTH-1:0]             ld_dst_stride_i,
  input  logic [ADDR_WIDTH-1:0]             ld_src_rewind_i,
  input  logic [ADDR_WIDTH-1:0]             ld_dst_rewind_i,
  input  logic [ADDR_WIDTH-1:0]             next_src_term_i,
  input  logic [ADDR_WIDTH-1:0]             next_dst_term_i,
  output logic [ADDR_WIDTH-1:0]             src_term_o,
  output logic [ADDR_WIDTH-1:0]             dst_term_o
);
  import sncag_pkg::*;

  logic [EXTENT_W-1:0]   ext_q, cnt_q, cnt_inc;
  logic [ADDR_WIDTH-1:0] src_str_q, dst_str_q, src_rw_q, dst_rw_q;
  logic [ADDR_WIDTH-1:0] src_term_q, dst_term_q;
  logic                  act, hit, wrap;

  assign cnt_inc    = cnt_q + 1'b1;
  assign hit        = (cnt_inc == ext_q);
  assign act        = in_use_i & carry_i;
  // outermost axis never rewinds; its hit ends the walk
  assign wrap       = hit & ~outer_i;
  assign carry_o    = in_use_i ? (carry_i & hit) : carry_i;
  assign ext_zero_o = in_use_i & (ext_q == '0);
  assign src_term_o = src_term_q;
  assign dst_term_o = dst_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q     <= '0;
      src_str_q <= '0;
      dst_str_q <= '0;
      src_rw_q  <= '0;
      dst_rw_q  <= '0;
    end else begin
      if (ctrl_i.load && sel_i) begin
        ext_q     <= ld_extent_i;
        src_str_q <= ld_src_stride_i;
        dst_str_q <= ld_dst_stride_i;
      end
      if (ctrl_i.rewind && sel_i) begin
        src_rw_q <= ld_src_rewind_i;
        dst_rw_q <= ld_dst_rewind_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      src_term_q <= '0;
      dst_term_q <= '0;
    end else begin
      if (ctrl_i.clr) begin
        cnt_q <= '0;
      end else if (ctrl_i.step && act) begin
        cnt_q <= wrap ? '0 : cnt_inc;
      end
      if (ctrl_i.step) begin
        // latch this axis' share of the position move
        if (!act) begin
          src_term_q <= '0;
          dst_term_q <= '0;
        end else if (wrap) begin
          src_term_q <= src_rw_q;
          dst_term_q <= dst_rw_q;
        end else begin
          src_term_q <= src_str_q;
          dst_term_q <= dst_str_q;
        end
      end else if (ctrl_i.shift) begin
        src_term_q <= next_src_term_i;
        dst_term_q <= next_dst_term_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/strided_nd_copy_address_gen.sv
// Top level of the strided N-d copy address generator: sequencer, positions, row of axis slices.
// Uses sncag_pkg, sncag_stream_if and sncag_cell.
//
//   port    dir  kind              beat moves
//   req_i   in   stream, sink      one command: load, start or next
//   rsp_o   out  stream, source    one address pair or done status (next only)
//   cfg_*   in   write port        elem_size (index 0) or rank (index 1)
//
// Load, then rewind; start clears, then adds offset; active next steps, then walks used axes.
// The position adder takes one axis term per cycle as terms shift down the slice row.
// Reset clears descriptors, counters and positions at once; no clearing pass.
// A finished result waits in the output register; the next command is taken in the idle
// state when that register is free or is emptied in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module strided_nd_copy_address_gen #(
  parameter int unsigned MAX_RANK   = sncag_pkg::MAX_RANK_DEF,
  parameter int unsigned ADDR_WIDTH = sncag_pkg::ADDR_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sncag_stream_if.sink                       req_i,
  sncag_stream_if.source                     rsp_o,
  input  logic                               cfg_we_i,
  input  logic [sncag_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sncag_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import sncag_pkg::*;

  localparam int unsigned RK_W = $clog2(MAX_RANK + 1);

  state_e                state_q, state_d;
  phase_e                phase_q;
  cell_ctrl_t            ctrl;
  logic                  req_ready, req_acc, start_add, walk_add;
  logic [RK_W-1:0]       used_rank, sweep_q, sweep_d;
  logic [ELEM_W-1:0]     es_q;
  logic [RANK_W-1:0]     rank_q;

  logic [AXIS_W-1:0]          ld_axis_q;
  logic signed [STRIDE_W-1:0] ld_src_s_q, ld_dst_s_q;
  logic signed [K_W-1:0]      ld_k_q, k_d;
  logic signed [SCALE_W-1:0]  one_m_ext;
  logic signed [STRIDE_W+ELEM_W:0] src_sb, dst_sb;
  logic signed [63:0]         src_sb_w, dst_sb_w, src_rw_w, dst_rw_w;
  logic signed [RW_W-1:0]     src_rw, dst_rw;

  logic [OFFSET_W+ELEM_W-1:0] src_op, dst_op;
  logic [63:0]                src_op_w, dst_op_w, src_base_w, dst_base_w;
  logic [63:0]                rd_pos_w, wr_pos_w;
  logic [ADDR_WIDTH-1:0]      src_pos_q, dst_pos_q, src_prod_q, dst_prod_q;

  logic                  rsp_valid_q;
  out_item_t             rsp_q;

  logic [MAX_RANK:0]     carry;
  logic [MAX_RANK-1:0]   sel, in_use, ext_zero;
  logic [ADDR_WIDTH-1:0] src_term [MAX_RANK+1];
  logic [ADDR_WIDTH-1:0] dst_term [MAX_RANK+1];

  assign used_rank = (int'(rank_q) > MAX_RANK) ? RK_W'(MAX_RANK) : RK_W'(rank_q);

  assign req_i.ready = req_ready;
  assign req_acc     = req_i.valid & req_ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q   <= ELEM_W'(1);
      rank_q <= RANK_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ELEM_SIZE: es_q   <= cfg_wdata_i[ELEM_W-1:0];
        CFG_RANK:      rank_q <= cfg_wdata_i[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    ctrl      = '0;
    req_ready = 1'b0;
    start_add = 1'b0;
    walk_add  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready = ~rsp_valid_q | rsp_o.ready;
        if (req_i.valid && req_ready) begin
          case (req_i.data.cmd)
            CMD_LOAD: begin
              ctrl.load = 1'b1;
              state_d   = ST_REWIND;
            end
            CMD_START: begin
              ctrl.clr = 1'b1;
              state_d  = ST_START;
            end
            CMD_NEXT: begin
              if (phase_q == PH_ACTIVE) begin
                ctrl.step = 1'b1;
                if (used_rank != '0) begin
                  state_d = ST_WALK;
                  sweep_d = used_rank - 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_REWIND: begin
        ctrl.rewind = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_START: begin
        start_add = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_WALK: begin
        // add the outermost pending term, shift the rest down
        ctrl.shift = 1'b1;
        walk_add   = 1'b1;
        if (sweep_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q - 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- descriptor scaling ----------------
  assign src_sb    = req_i.data.src_stride * $signed({1'b0, es_q});
  assign dst_sb    = req_i.data.dst_stride * $signed({1'b0, es_q});
  assign src_sb_w  = 64'(src_sb);
  assign dst_sb_w  = 64'(dst_sb);
  assign one_m_ext = SCALE_W'(1) - SCALE_W'(req_i.data.extent);
  assign k_d       = one_m_ext * $signed({1'b0, es_q});

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      ld_axis_q  <= req_i.data.axis;
      ld_src_s_q <= req_i.data.src_stride;
      ld_dst_s_q <= req_i.data.dst_stride;
      ld_k_q     <= k_d;
    end
  end

  // rewind step = stride * elem_size * (1 - extent)
  assign src_rw   = ld_src_s_q * ld_k_q;
  assign dst_rw   = ld_dst_s_q * ld_k_q;
  assign src_rw_w = 64'(src_rw);
  assign dst_rw_w = 64'(dst_rw);

  // ---------------- positions ----------------
  assign src_op     = req_i.data.src_offset * (OFFSET_W + ELEM_W)'(es_q);
  assign dst_op     = req_i.data.dst_offset * (OFFSET_W + ELEM_W)'(es_q);
  assign src_op_w   = 64'(src_op);
  assign dst_op_w   = 64'(dst_op);
  assign src_base_w = 64'(req_i.data.src_addr);
  assign dst_base_w = 64'(req_i.data.dst_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_pos_q  <= '0;
      dst_pos_q  <= '0;
      src_prod_q <= '0;
      dst_prod_q <= '0;
    end else if (ctrl.clr) begin
      src_pos_q  <= src_base_w[ADDR_WIDTH-1:0];
      dst_pos_q  <= dst_base_w[ADDR_WIDTH-1:0];
      src_prod_q <= src_op_w[ADDR_WIDTH-1:0];
      dst_prod_q <= dst_op_w[ADDR_WIDTH-1:0];
    end else if (start_add) begin
      src_pos_q <= src_pos_q + src_prod_q;
      dst_pos_q <= dst_pos_q + dst_prod_q;
    end else if (walk_add) begin
      src_pos_q <= src_pos_q + src_term[0];
      dst_pos_q <= dst_pos_q + dst_term[0];
    end
  end

  // ---------------- walk phase ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (ctrl.clr) begin
      phase_q <= (|ext_zero) ? PH_DONE : PH_ACTIVE;
    end else if (ctrl.step && carry[0]) begin
      phase_q <= PH_DONE;
    end
  end

  // ---------------- response register ----------------
  assign rd_pos_w = 64'(src_pos_q);
  assign wr_pos_w = 64'(dst_pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_acc && req_i.data.cmd == CMD_NEXT) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.data.cmd == CMD_NEXT) begin
      if (phase_q == PH_ACTIVE) begin
        rsp_q.valid_res  <= 1'b1;
        rsp_q.read_addr  <= rd_pos_w[FIELD_ADDR_W-1:0];
        rsp_q.write_addr <= wr_pos_w[FIELD_ADDR_W-1:0];
        rsp_q.last       <= carry[0];
        rsp_q.done_res   <= 1'b0;
      end else begin
        rsp_q <= '{valid_res: 1'b0, read_addr: '0, write_addr: '0,
                   last: 1'b0, done_res: 1'b1};
      end
    end
  end

  // ---------------- row of axis slices ----------------
  // carry enters at the innermost slice and ripples outward
  assign carry[MAX_RANK]    = 1'b1;
  assign src_term[MAX_RANK] = '0;
  assign dst_term[MAX_RANK] = '0;

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_axis
    assign in_use[g] = (int'(used_rank) > g);
    assign sel[g]    = (state_q == ST_REWIND) ? (int'(ld_axis_q) == g)
                                              : (int'(req_i.data.axis) == g);

    sncag_cell #(
      .ADDR_WIDTH(ADDR_WIDTH)
    ) u_axis (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctrl_i          (ctrl),
      .sel_i           (sel[g]),
      .in_use_i        (in_use[g]),
      .outer_i         (g == 0),
      .carry_i         (carry[g+1]),
      .carry_o         (carry[g]),
      .ext_zero_o      (ext_zero[g]),
      .ld_extent_i     (req_i.data.extent),
      .ld_src_stride_i (src_sb_w[ADDR_WIDTH-1:0]),
      .ld_dst_stride_i (dst_sb_w[ADDR_WIDTH-1:0]),
      .ld_src_rewind_i (src_rw_w[ADDR_WIDTH-1:0]),
      .ld_dst_rewind_i (dst_rw_w[ADDR_WIDTH-1:0]),
      .next_src_term_i (src_term[g+1]),
      .next_dst_term_i (dst_term[g+1]),
      .src_term_o      (src_term[g]),
      .dst_term_o      (dst_term[g])
    );
  end

endmodule

`default_nettype wire

>>> rtl/sncag_chk.sv
// Port-level checks for strided_nd_copy_address_gen, attached by bind.
// Uses sncag_pkg for the response beat type.
`timescale 1ns / 1ps
`default_nettype none

module sncag_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input sncag_pkg::out_item_t  rsp_data_i
);
  import sncag_pkg::*;

  // a stalled response beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response beat changed while stalled");

  // never take a command while a waiting response is not being drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |-> !rsp_valid_i || rsp_ready_i)
    else $error("command taken while response slot full");

  // a beat is either an element or a done status, and last marks an element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_data_i.valid_res != rsp_data_i.done_res) &&
                    (!rsp_data_i.last || rsp_data_i.valid_res))
    else $error("inconsistent response flags");

  // a done status carries no addresses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.done_res |->
      rsp_data_i.read_addr == '0 && rsp_data_i.write_addr == '0)
    else $error("done status with nonzero address");

endmodule

bind strided_nd_copy_address_gen sncag_chk u_sncag_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

`default_nettype wire
